// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and helpers of the linear blend skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int MAX_BONES   = 256;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int MAT_ELEMS   = 12;
  localparam int MEM_DEPTH   = MAX_BONES * MAT_ELEMS;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_INFL  = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INFL,
    OP_EMPTY
  } op_kind_t;

  // One classified request. For a load, px carries the element value.
  typedef struct packed {
    op_kind_t           kind;
    addr_t              addr;
    logic               bone_ok;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        w;
    logic               last;
    logic               pclip;
  } op_t;

  // Saturate to 32 bits signed; bit 32 of the result is the clip flag.
  function automatic logic [32:0] sat32(input logic signed [49:0] x);
    logic [32:0] r;
    if (x > 50'sh7FFFFFFF) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (x < -50'sh80000000) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/lbs_in_if.sv =====
// ----------------------------------------------------------------------------
// lbs_in_if
// Request channel of the skinning unit: valid, ready and one request.
// ----------------------------------------------------------------------------
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [7:0]         bone_index;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  logic [16:0]        weight;
  logic               last_influence;

  modport source(output valid, command, bone_index, element_index, element_value,
                 offset_x, offset_y, disp_x, disp_y, disp_z, weight, last_influence,
                 input ready);
  modport sink(input valid, command, bone_index, element_index, element_value,
               offset_x, offset_y, disp_x, disp_y, disp_z, weight, last_influence,
               output ready);
endinterface

// ----------------------------------------------------------------------------
// lbs_out_if
// Result channel of the skinning unit: valid, ready and one vertex.
// ----------------------------------------------------------------------------
interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               saturated;

  modport source(output valid, pos_x, pos_y, pos_z, saturated, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

// ===== src/lbs_front.sv =====
// ----------------------------------------------------------------------------
// lbs_front
// Accepts requests, drops those with no effect, forms the transform input
// vector and the store address, and queues the result in a two-entry FIFO.
// ----------------------------------------------------------------------------
module lbs_front (
  input  logic         clk,
  input  logic         rst,
  lbs_in_if.sink       din,
  output lbs_pkg::op_t q_op,
  output logic         q_valid,
  input  logic         q_ready
);

  lbs_pkg::op_t       fifo [2];
  logic               wp;
  logic               rp;
  logic [1:0]         cnt;
  lbs_pkg::op_t       op_new;
  logic               keep;
  logic               push;
  logic               pop;
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic [32:0]        sat_x;
  logic [32:0]        sat_y;
  logic               elem_ok;
  lbs_pkg::addr_t     base;

  always_comb begin
    sum_x   = 33'(din.offset_x) + 33'(din.disp_x);
    sum_y   = 33'(din.offset_y) + 33'(din.disp_y);
    sat_x   = lbs_pkg::sat32(50'(sum_x));
    sat_y   = lbs_pkg::sat32(50'(sum_y));
    elem_ok = 32'(din.element_index) < lbs_pkg::MAT_ELEMS;
    base    = lbs_pkg::addr_t'({din.bone_index, 3'b000})
            + lbs_pkg::addr_t'({din.bone_index, 2'b00});

    op_new         = '0;
    op_new.bone_ok = 32'(din.bone_index) < lbs_pkg::MAX_BONES;
    op_new.w       = din.weight;
    op_new.last    = din.last_influence;
    op_new.pz      = din.disp_z;
    keep           = 1'b0;
    unique case (din.command)
      lbs_pkg::CMD_LOAD: begin
        op_new.kind = lbs_pkg::OP_LOAD;
        op_new.addr = base + lbs_pkg::addr_t'(din.element_index);
        op_new.px   = din.element_value;
        keep        = op_new.bone_ok && elem_ok;
      end
      lbs_pkg::CMD_INFL: begin
        op_new.kind  = lbs_pkg::OP_INFL;
        op_new.addr  = base;
        op_new.px    = sat_x[31:0];
        op_new.py    = sat_y[31:0];
        op_new.pclip = sat_x[32] | sat_y[32];
        keep         = 1'b1;
      end
      lbs_pkg::CMD_EMPTY: begin
        op_new.kind = lbs_pkg::OP_EMPTY;
        keep        = 1'b1;
      end
      default: begin
        op_new.kind = lbs_pkg::OP_EMPTY;
        keep        = 1'b0;
      end
    endcase
  end

  assign din.ready = (cnt != 2'd2);
  assign push      = din.valid && din.ready && keep;
  assign q_valid   = (cnt != 2'd0);
  assign q_op      = fifo[rp];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      fifo[wp] <= op_new;
    end
  end

endmodule

// ===== src/lbs_back.sv =====
// ----------------------------------------------------------------------------
// lbs_back
// Holds the bone matrix store and runs each influence through one shared
// multiplier: per row, three matrix products and the translation, a weight product, then the row sum.
// ----------------------------------------------------------------------------
module lbs_back (
  input  logic         clk,
  input  logic         rst,
  input  lbs_pkg::op_t q_op,
  input  logic         q_valid,
  output logic         q_ready,
  lbs_out_if.source    dout
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_WMUL,
    S_WACC,
    S_EMIT
  } state_t;

  localparam logic signed [49:0] SUM_MAX = 50'sh7FFFFFFFFFFF;
  localparam logic signed [49:0] SUM_MIN = -50'sh800000000000;

  state_t             state;
  lbs_pkg::op_t       cur;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [49:0] acc;
  logic signed [65:0] prod;
  logic signed [47:0] sums [3];
  logic               clip;
  logic [31:0]        mem [lbs_pkg::MEM_DEPTH];
  logic signed [31:0] rdata;
  lbs_pkg::addr_t     raddr;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [31:0] pcol;
  logic [32:0]        acc_sat;
  logic signed [49:0] sum_new;
  logic               out_free;
  logic               pop;
  logic               mem_we;
  logic [32:0]        ex;
  logic [32:0]        ey;
  logic [32:0]        ez;

  assign out_free = !dout.valid || dout.ready;
  assign q_ready  = (state == S_IDLE) && (q_op.kind != lbs_pkg::OP_EMPTY || out_free);
  assign pop      = q_valid && q_ready;
  assign mem_we   = pop && q_op.kind == lbs_pkg::OP_LOAD;
  assign raddr    = cur.addr + lbs_pkg::addr_t'({row, col});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_op.addr] <= q_op.px;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    unique case (col)
      2'd0:    pcol = cur.px;
      2'd1:    pcol = cur.py;
      default: pcol = cur.pz;
    endcase
    acc_sat = lbs_pkg::sat32(acc);
    if (state == S_WMUL) begin
      ma = 33'(signed'(acc_sat[31:0]));
      mb = signed'({16'd0, cur.w});
    end else begin
      ma = 33'(rdata);
      mb = 33'(pcol);
    end
    sum_new = 50'(sums[row]) + 50'(prod >>> lbs_pkg::WEIGHT_BITS);
    ex = lbs_pkg::sat32(50'(sums[0]));
    ey = lbs_pkg::sat32(50'(sums[1]));
    ez = lbs_pkg::sat32(50'(sums[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row        <= 2'd0;
      col        <= 2'd0;
      clip       <= 1'b0;
      sums[0]    <= '0;
      sums[1]    <= '0;
      sums[2]    <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        dout.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= q_op;
            row <= 2'd0;
            col <= 2'd0;
            acc <= '0;
            unique case (q_op.kind)
              lbs_pkg::OP_LOAD: state <= S_IDLE;
              lbs_pkg::OP_EMPTY: begin
                // Drops any partial vertex and emits zero.
                sums[0]        <= '0;
                sums[1]        <= '0;
                sums[2]        <= '0;
                clip           <= 1'b0;
                dout.valid     <= 1'b1;
                dout.pos_x     <= '0;
                dout.pos_y     <= '0;
                dout.pos_z     <= '0;
                dout.saturated <= 1'b0;
              end
              default: begin
                if (q_op.bone_ok) begin
                  clip  <= clip | q_op.pclip;
                  state <= S_RD;
                end else if (q_op.last) begin
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          if (col == 2'd3) begin
            acc   <= acc + 50'(rdata);
            state <= S_WMUL;
          end else begin
            prod  <= ma * mb;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc   <= acc + 50'(prod >>> lbs_pkg::FRAC_BITS);
          col   <= col + 2'd1;
          state <= S_RD;
        end
        S_WMUL: begin
          prod <= ma * mb;
          clip <= clip | acc_sat[32];
          state <= S_WACC;
        end
        S_WACC: begin
          if (sum_new > SUM_MAX) begin
            sums[row] <= SUM_MAX[47:0];
            clip      <= 1'b1;
          end else if (sum_new < SUM_MIN) begin
            sums[row] <= SUM_MIN[47:0];
            clip      <= 1'b1;
          end else begin
            sums[row] <= sum_new[47:0];
          end
          if (row == 2'd2) begin
            state <= cur.last ? S_EMIT : S_IDLE;
          end else begin
            row   <= row + 2'd1;
            col   <= 2'd0;
            acc   <= '0;
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            dout.valid     <= 1'b1;
            dout.pos_x     <= ex[31:0];
            dout.pos_y     <= ey[31:0];
            dout.pos_z     <= ez[31:0];
            dout.saturated <= clip | ex[32] | ey[32] | ez[32];
            sums[0]        <= '0;
            sums[1]        <= '0;
            sums[2]        <= '0;
            clip           <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE)
    else $error("request taken while an influence is in progress");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row != 2'd3)
    else $error("row counter out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> dout.valid && state == S_IDLE)
    else $error("vertex emit lost");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> sums[0] == '0 && !clip)
    else $error("vertex sum not cleared after emit");

endmodule

// ===== src/linear_blend_vertex_skinning_unit.sv =====
// Loads are written to the matrix store, and empty vertices register a zero result,
// when the engine takes them from the queue. An influence occupies the shared
// multiplier for three rows of column products, translation add, weight product
// and row sum; a last influence shows its vertex once the output is free. Loads and
// empty vertices sustain one request per cycle while the engine is idle, empties only with a free output.
// Synchronous active-high reset clears sums, flags, queue and output valid.
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit
// Top level: request front end with a short queue, and the skinning engine.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_unit (
  input logic       clk,
  input logic       rst,
  lbs_in_if.sink    din,
  lbs_out_if.source dout
);

  lbs_pkg::op_t q_op;
  logic         q_valid;
  logic         q_ready;

  lbs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .q_op    (q_op),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  lbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_op    (q_op),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .dout    (dout)
  );

endmodule
